### src/sof_length_crc_frame_parser_macros.svh
// Assertion macros shared by the frame parser RTL.
`ifndef SOF_LENGTH_CRC_FRAME_PARSER_MACROS_SVH
`define SOF_LENGTH_CRC_FRAME_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SFP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame parser: same-cycle check failed");
`define SFP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame parser: next-cycle check failed");
`else
`define SFP_ASSERT_IMP(lbl, ante, cons)
`define SFP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/sfp_pkg.sv
// Shared constants, types and the CRC function of the frame parser.
`default_nettype none
package sfp_pkg;

	localparam int MAX_PAYLOAD_BYTES_DEF = 64;
	localparam int MAX_FRAME_BYTES_DEF   = 80;

	// Frame layout, as byte positions counted from the first start byte.
	localparam int OVERHEAD_BYTES  = 16;
	localparam int HUNT_SECOND_POS = 1;
	localparam int VERSION_POS     = 2;
	localparam int TYPE_POS        = 3;
	localparam int LEN_LO_POS      = 4;
	localparam int LEN_HI_POS      = 5;
	localparam int LENGTH_DONE_POS = 6;
	localparam int SEQ_START       = 6;
	localparam int TS_START        = 10;
	localparam int PAYLOAD_START   = 14;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION  = 2'd2;

	localparam logic [CFG_W-1:0] START_FIRST_RST  = 8'hAA;
	localparam logic [CFG_W-1:0] START_SECOND_RST = 8'h55;
	localparam logic [CFG_W-1:0] EXP_VERSION_RST  = 8'h01;

	localparam logic [1:0] STATUS_GOOD    = 2'd0;
	localparam logic [1:0] STATUS_LEN_ERR = 2'd1;
	localparam logic [1:0] STATUS_VER_ERR = 2'd2;
	localparam logic [1:0] STATUS_CRC_ERR = 2'd3;

	// Outcome of one accepted byte.
	typedef enum logic [2:0] {
		EVT_NONE,
		EVT_LEN_ERR,
		EVT_VER_ERR,
		EVT_CRC_ERR,
		EVT_GOOD_EMPTY,
		EVT_GOOD_PAYLOAD
	} sfp_evt_t;

	typedef struct packed {
		logic take_byte;
		logic rd_en;
		logic emit_load;
	} sfp_cmd_t;

	typedef struct packed {
		logic     result_pos;
		logic     slot_free;
		logic     emit_last;
		sfp_evt_t evt;
	} sfp_sts_t;

	// CRC-16/CCITT-FALSE update by one byte, MSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### src/sof_length_crc_frame_parser.sv
// Top level of the start-of-frame, length and CRC framed packet parser.
//
// Usage. Received bytes arrive on the rx channel (rx_valid, rx_ready, rx_byte), one byte per
// transaction. Results leave on the res channel (res_valid, res_ready and the result fields).
// Three configuration registers (first start byte, second start byte, expected version) are
// written through cfg_wr_en, cfg_index and cfg_wr_data while the parser is idle.
// Throughput: a byte is taken every cycle while the frame is received, save when a byte that
// could produce a result waits for a busy result register. A good frame with n payload bytes
// then gives n results, since each result reads the payload memory into a registered read
// stage before it loads the result register; no byte is taken while they are given. A good
// frame with an empty payload and every error give one result, with no read stage.
// Timing: an error or an empty good frame gives its result in the cycle after the byte that
// closes or breaks the frame is taken; a frame with a payload gives its first result once the
// read stage and then the load stage have been through.
// Reset: configuration registers return to 0xAA, 0x55 and 0x01, the error totals clear and the
// parser hunts for a start byte. The payload memory is not cleared and needs no clearing pass.
// Stalls: a result waits in the output register while res_ready is low. Bytes that cannot end a
// frame are still taken meanwhile, except while a frame's payload results are being given; a
// byte that could produce a result waits until the register is free.
`default_nettype none
module sof_length_crc_frame_parser #(
	parameter int MAX_PAYLOAD_BYTES = sfp_pkg::MAX_PAYLOAD_BYTES_DEF,
	parameter int MAX_FRAME_BYTES   = sfp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sfp_pkg::CFG_W-1:0]     cfg_wr_data,
	input  wire logic                          rx_valid,
	output logic                               rx_ready,
	input  wire logic [7:0]                    rx_byte,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic [1:0]                         status,
	output logic [7:0]                         frame_type,
	output logic [6:0]                         payload_length,
	output logic [31:0]                        sequence_number,
	output logic [31:0]                        timestamp,
	output logic [7:0]                         payload_byte,
	output logic [5:0]                         byte_position,
	output logic                               last,
	output logic [31:0]                        crc_error_count,
	output logic [31:0]                        length_error_count,
	output logic [31:0]                        version_error_count
);

	// Commands from the controller and status back from the datapath are the only links.
	sfp_pkg::sfp_cmd_t cmd;
	sfp_pkg::sfp_sts_t sts;

	sfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfp_dp #(
		.MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
		.MAX_FRAME_BYTES   (MAX_FRAME_BYTES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_wr_data         (cfg_wr_data),
		.rx_byte             (rx_byte),
		.cmd                 (cmd),
		.sts                 (sts),
		.res_ready           (res_ready),
		.res_valid           (res_valid),
		.status              (status),
		.frame_type          (frame_type),
		.payload_length      (payload_length),
		.sequence_number     (sequence_number),
		.timestamp           (timestamp),
		.payload_byte        (payload_byte),
		.byte_position       (byte_position),
		.last                (last),
		.crc_error_count     (crc_error_count),
		.length_error_count  (length_error_count),
		.version_error_count (version_error_count)
	);

endmodule
`default_nettype wire

### src/sfp_dp.sv
// Datapath of the frame parser: frame registers, CRC, payload memory and result register.
`default_nettype none
module sfp_dp #(
	parameter int MAX_PAYLOAD_BYTES = sfp_pkg::MAX_PAYLOAD_BYTES_DEF,
	parameter int MAX_FRAME_BYTES   = sfp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sfp_pkg::CFG_W-1:0]    cfg_wr_data,
	input  wire logic [7:0]                   rx_byte,
	input  wire sfp_pkg::sfp_cmd_t            cmd,
	output sfp_pkg::sfp_sts_t                 sts,
	input  wire logic                         res_ready,
	output logic                              res_valid,
	output logic [1:0]                        status,
	output logic [7:0]                        frame_type,
	output logic [6:0]                        payload_length,
	output logic [31:0]                       sequence_number,
	output logic [31:0]                       timestamp,
	output logic [7:0]                        payload_byte,
	output logic [5:0]                        byte_position,
	output logic                              last,
	output logic [31:0]                       crc_error_count,
	output logic [31:0]                       length_error_count,
	output logic [31:0]                       version_error_count
);

	localparam int TOTAL_MAX = (MAX_FRAME_BYTES > MAX_PAYLOAD_BYTES + sfp_pkg::OVERHEAD_BYTES)
		? MAX_FRAME_BYTES : MAX_PAYLOAD_BYTES + sfp_pkg::OVERHEAD_BYTES;
	localparam int POS_W = $clog2(TOTAL_MAX + 1);
	localparam int LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);
	localparam int AW    = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

	logic [7:0]        sof1_q, sof2_q, ver_exp_q;
	logic [POS_W-1:0]  pos_q, total_q;
	logic [15:0]       crc_q;
	logic [AW-1:0]     idx_q;
	logic [31:0]       crc_cnt_q, len_cnt_q, ver_cnt_q;
	logic [7:0]        hdr_ver_q, hdr_type_q, len_lo_q, crc_lo_q;
	logic [LEN_W-1:0]  len_q;
	logic [31:0]       seq_q, ts_q;
	logic [7:0]        payload_mem [MAX_PAYLOAD_BYTES];
	logic [7:0]        rd_data_q;

	logic              res_valid_q;
	logic [1:0]        status_q;
	logic [7:0]        type_out_q, pbyte_out_q;
	logic [6:0]        plen_out_q;
	logic [31:0]       seq_out_q, ts_out_q;
	logic [5:0]        bpos_out_q;
	logic              last_out_q;

	logic              hunting, total_known, in_body, crc_pos, over_limit;
	logic              len_bad, at_len_done, at_end, emit_last;
	logic              frame_take, byte_result, frame_restart, mem_we;
	logic [POS_W:0]    pos_p1, pos_p2, total_x;
	logic [15:0]       len_full, rx_crc;
	logic [1:0]        seq_lane, ts_lane;
	logic [AW-1:0]     wr_addr;
	logic [POS_W-1:0]  hunt_next;
	sfp_pkg::sfp_evt_t evt;

	assign hunting     = pos_q < POS_W'(sfp_pkg::VERSION_POS);
	assign pos_p1      = {1'b0, pos_q} + (POS_W+1)'(1);
	assign pos_p2      = {1'b0, pos_q} + (POS_W+1)'(2);
	assign total_x     = {1'b0, total_q};
	assign total_known = total_q != '0;
	assign in_body     = total_known && (pos_p2 < total_x);
	assign crc_pos     = (pos_q < POS_W'(sfp_pkg::PAYLOAD_START)) || in_body;
	assign over_limit  = pos_q >= POS_W'(MAX_FRAME_BYTES);
	assign len_full    = {rx_byte, len_lo_q};
	assign len_bad     = len_full > 16'(MAX_PAYLOAD_BYTES);
	assign at_len_done = pos_p1 == (POS_W+1)'(sfp_pkg::LENGTH_DONE_POS);
	assign at_end      = total_known && (pos_p1 == total_x);
	assign rx_crc      = {rx_byte, crc_lo_q};
	assign seq_lane    = 2'(pos_q - POS_W'(sfp_pkg::SEQ_START));
	assign ts_lane     = 2'(pos_q - POS_W'(sfp_pkg::TS_START));
	assign wr_addr     = AW'(pos_q - POS_W'(sfp_pkg::PAYLOAD_START));
	assign emit_last   = idx_q == AW'(len_q - LEN_W'(1));

	always_comb begin
		evt = sfp_pkg::EVT_NONE;
		if (!hunting) begin
			if (over_limit) begin
				evt = sfp_pkg::EVT_LEN_ERR;
			end else if (at_len_done && len_bad) begin
				evt = sfp_pkg::EVT_LEN_ERR;
			end else if (at_end) begin
				if (hdr_ver_q != ver_exp_q) begin
					evt = sfp_pkg::EVT_VER_ERR;
				end else if (rx_crc != crc_q) begin
					evt = sfp_pkg::EVT_CRC_ERR;
				end else if (len_q == '0) begin
					evt = sfp_pkg::EVT_GOOD_EMPTY;
				end else begin
					evt = sfp_pkg::EVT_GOOD_PAYLOAD;
				end
			end
		end
	end

	// Second start byte wins over a repeated first start byte.
	always_comb begin
		if (pos_q == POS_W'(sfp_pkg::HUNT_SECOND_POS) && rx_byte == sof2_q) begin
			hunt_next = POS_W'(sfp_pkg::VERSION_POS);
		end else if (rx_byte == sof1_q) begin
			hunt_next = POS_W'(sfp_pkg::HUNT_SECOND_POS);
		end else begin
			hunt_next = '0;
		end
	end

	assign frame_take    = cmd.take_byte && !hunting && (evt == sfp_pkg::EVT_NONE);
	assign byte_result   = cmd.take_byte && (evt != sfp_pkg::EVT_NONE)
		&& (evt != sfp_pkg::EVT_GOOD_PAYLOAD);
	assign frame_restart = byte_result || (cmd.emit_load && emit_last);
	assign mem_we        = frame_take && (pos_q >= POS_W'(sfp_pkg::PAYLOAD_START)) && in_body;

	// A result can only come from the length high byte, the closing byte or an overrun.
	assign sts.result_pos = !hunting && (over_limit
		|| pos_q == POS_W'(sfp_pkg::LEN_HI_POS) || at_end);
	assign sts.slot_free  = !res_valid_q || res_ready;
	assign sts.emit_last  = emit_last;
	assign sts.evt        = evt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof1_q      <= sfp_pkg::START_FIRST_RST;
			sof2_q      <= sfp_pkg::START_SECOND_RST;
			ver_exp_q   <= sfp_pkg::EXP_VERSION_RST;
			pos_q       <= '0;
			total_q     <= '0;
			crc_q       <= sfp_pkg::CRC_INIT;
			idx_q       <= '0;
			crc_cnt_q   <= '0;
			len_cnt_q   <= '0;
			ver_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					sfp_pkg::CFG_START_FIRST:  sof1_q    <= cfg_wr_data;
					sfp_pkg::CFG_START_SECOND: sof2_q    <= cfg_wr_data;
					sfp_pkg::CFG_EXP_VERSION:  ver_exp_q <= cfg_wr_data;
					default: ;
				endcase
			end

			if (frame_restart) begin
				pos_q   <= '0;
				total_q <= '0;
				crc_q   <= sfp_pkg::CRC_INIT;
			end else if (frame_take) begin
				pos_q <= POS_W'(pos_p1);
				if (crc_pos) begin
					crc_q <= sfp_pkg::crc16_byte(crc_q, rx_byte);
				end
				if (at_len_done) begin
					total_q <= POS_W'(sfp_pkg::OVERHEAD_BYTES) + POS_W'(len_full);
				end
			end else if (cmd.take_byte && hunting) begin
				pos_q <= hunt_next;
			end

			if (cmd.emit_load) begin
				idx_q <= emit_last ? '0 : idx_q + AW'(1);
			end

			if (cmd.take_byte) begin
				case (evt)
					sfp_pkg::EVT_LEN_ERR: len_cnt_q <= len_cnt_q + 32'd1;
					sfp_pkg::EVT_VER_ERR: ver_cnt_q <= ver_cnt_q + 32'd1;
					sfp_pkg::EVT_CRC_ERR: crc_cnt_q <= crc_cnt_q + 32'd1;
					default: ;
				endcase
			end

			if (byte_result || cmd.emit_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			if (pos_q == POS_W'(sfp_pkg::VERSION_POS)) begin
				hdr_ver_q <= rx_byte;
			end else if (pos_q == POS_W'(sfp_pkg::TYPE_POS)) begin
				hdr_type_q <= rx_byte;
			end else if (pos_q == POS_W'(sfp_pkg::LEN_LO_POS)) begin
				len_lo_q <= rx_byte;
			end else if (pos_q == POS_W'(sfp_pkg::LEN_HI_POS)) begin
				len_q <= LEN_W'(len_full);
			end else if (pos_q < POS_W'(sfp_pkg::TS_START)) begin
				seq_q[{seq_lane, 3'b000} +: 8] <= rx_byte;
			end else if (pos_q < POS_W'(sfp_pkg::PAYLOAD_START)) begin
				ts_q[{ts_lane, 3'b000} +: 8] <= rx_byte;
			end else if (pos_p2 == total_x) begin
				crc_lo_q <= rx_byte;
			end
		end
		if (mem_we) begin
			payload_mem[wr_addr] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= payload_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			status_q    <= sfp_pkg::STATUS_GOOD;
			type_out_q  <= hdr_type_q;
			plen_out_q  <= 7'(len_q);
			seq_out_q   <= seq_q;
			ts_out_q    <= ts_q;
			pbyte_out_q <= rd_data_q;
			bpos_out_q  <= 6'(idx_q);
			last_out_q  <= emit_last;
		end else if (byte_result) begin
			type_out_q  <= '0;
			plen_out_q  <= '0;
			seq_out_q   <= '0;
			ts_out_q    <= '0;
			pbyte_out_q <= '0;
			bpos_out_q  <= '0;
			last_out_q  <= 1'b1;
			case (evt)
				sfp_pkg::EVT_LEN_ERR: status_q <= sfp_pkg::STATUS_LEN_ERR;
				sfp_pkg::EVT_VER_ERR: status_q <= sfp_pkg::STATUS_VER_ERR;
				sfp_pkg::EVT_CRC_ERR: status_q <= sfp_pkg::STATUS_CRC_ERR;
				sfp_pkg::EVT_GOOD_EMPTY: begin
					status_q   <= sfp_pkg::STATUS_GOOD;
					type_out_q <= hdr_type_q;
					seq_out_q  <= seq_q;
					ts_out_q   <= ts_q;
				end
				default: status_q <= sfp_pkg::STATUS_GOOD;
			endcase
		end
	end

	assign res_valid       = res_valid_q;
	assign status          = status_q;
	assign frame_type      = type_out_q;
	assign payload_length  = plen_out_q;
	assign sequence_number = seq_out_q;
	assign timestamp       = ts_out_q;
	assign payload_byte    = pbyte_out_q;
	assign byte_position   = bpos_out_q;
	assign last            = last_out_q;

	// The totals move only when a new result is loaded, so the live values match the held result.
	assign crc_error_count     = crc_cnt_q;
	assign length_error_count  = len_cnt_q;
	assign version_error_count = ver_cnt_q;

endmodule
`default_nettype wire

### src/sfp_ctrl.sv
// Controller of the frame parser: byte intake and payload result sequencing.
`default_nettype none
`include "sof_length_crc_frame_parser_macros.svh"
module sfp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_valid,
	output logic                   rx_ready,
	input  wire sfp_pkg::sfp_sts_t sts,
	output sfp_pkg::sfp_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_RECV,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	state_t state_q;

	// A byte that cannot produce a result never needs the result register.
	assign rx_ready = (state_q == ST_RECV) && (sts.slot_free || !sts.result_pos);

	always_comb begin
		cmd.take_byte = rx_valid && rx_ready;
		cmd.rd_en     = state_q == ST_EMIT_RD;
		cmd.emit_load = (state_q == ST_EMIT_LD) && sts.slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
		end else begin
			case (state_q)
				ST_RECV: begin
					if (cmd.take_byte && sts.evt == sfp_pkg::EVT_GOOD_PAYLOAD) begin
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: state_q <= ST_EMIT_LD;
				ST_EMIT_LD: begin
					if (cmd.emit_load) begin
						state_q <= sts.emit_last ? ST_RECV : ST_EMIT_RD;
					end
				end
				default: state_q <= ST_RECV;
			endcase
		end
	end

	`SFP_ASSERT_IMP(a_result_has_slot, cmd.take_byte && sts.evt != sfp_pkg::EVT_NONE, sts.slot_free)
	`SFP_ASSERT_NXT(a_good_frame_reads, cmd.take_byte && sts.evt == sfp_pkg::EVT_GOOD_PAYLOAD, cmd.rd_en)
	`SFP_ASSERT_NXT(a_last_resumes_intake, cmd.emit_load && sts.emit_last, state_q == ST_RECV)

endmodule
`default_nettype wire

### test/tb_sof_length_crc_frame_parser.sv
// Self-checking testbench for the start-of-frame, length and CRC framed packet parser.
`default_nettype none
module tb_sof_length_crc_frame_parser;
	timeunit 1ns;
	timeprecision 1ps;

	// The watchdog gives up once quiet_cycles, the run of cycles in which no transaction of any
	// kind happens, reaches QUIET_LIMIT. A correct run never comes close.
	localparam int QUIET_LIMIT = 2000;

	// One decoded result, as the parser presents it on the result channel.
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  ftype;
		logic [6:0]  plen;
		logic [31:0] seq;
		logic [31:0] ts;
		logic [7:0]  pbyte;
		logic [5:0]  bpos;
		logic        lst;
		logic [31:0] crc_cnt;
		logic [31:0] len_cnt;
		logic [31:0] ver_cnt;
	} frame_result_t;

	// What a row of stimulus puts on the wire.
	typedef enum {
		ROW_GOOD,
		ROW_BAD_VERSION,
		ROW_BAD_CRC,
		ROW_BAD_BOTH,
		ROW_OVERSIZE,
		ROW_NOISE
	} row_kind_t;

	// A row describes one frame, or for noise rows up to four loose bytes packed
	// little-endian into seq with their count in len. Where typed is set, the result
	// of the byte that closes the row is the typed-in one: all descriptive fields zero,
	// last high, and the given status and error totals.
	typedef struct {
		row_kind_t   kind;
		logic [7:0]  ftype;
		logic [15:0] len;
		logic [31:0] seq;
		logic [31:0] ts;
		int          repeats;
		int          crc_tail;
		bit          typed;
		logic [1:0]  t_status;
		logic [31:0] t_crc;
		logic [31:0] t_len;
		logic [31:0] t_ver;
	} frame_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index = sfp_pkg::CFG_START_FIRST;
	logic [sfp_pkg::CFG_W-1:0]     cfg_wr_data = '0;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  frame_type;
	logic [6:0]  payload_length;
	logic [31:0] sequence_number;
	logic [31:0] timestamp;
	logic [7:0]  payload_byte;
	logic [5:0]  byte_position;
	logic        last;
	logic [31:0] crc_error_count;
	logic [31:0] length_error_count;
	logic [31:0] version_error_count;

	sof_length_crc_frame_parser dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_wr_data         (cfg_wr_data),
		.rx_valid            (rx_valid),
		.rx_ready            (rx_ready),
		.rx_byte             (rx_byte),
		.res_valid           (res_valid),
		.res_ready           (res_ready),
		.status              (status),
		.frame_type          (frame_type),
		.payload_length      (payload_length),
		.sequence_number     (sequence_number),
		.timestamp           (timestamp),
		.payload_byte        (payload_byte),
		.byte_position       (byte_position),
		.last                (last),
		.crc_error_count     (crc_error_count),
		.length_error_count  (length_error_count),
		.version_error_count (version_error_count)
	);

	always #4ns clk = ~clk;

	// Shadow of the parser: its registers, the frame being assembled and the error
	// totals. These move in step with every byte transaction that the driver issues.
	logic [7:0]  start_first;
	logic [7:0]  start_second;
	logic [7:0]  wanted_version;
	int unsigned frame_pos;
	int unsigned frame_total;
	logic [7:0]  hdr_type;
	logic [7:0]  hdr_version;
	logic [15:0] hdr_len;
	logic [31:0] hdr_seq;
	logic [31:0] hdr_ts;
	logic [7:0]  payload_mem [64];
	logic [15:0] crc_acc;
	logic [7:0]  crc_low;
	logic [31:0] crc_err_total;
	logic [31:0] len_err_total;
	logic [31:0] ver_err_total;

	frame_result_t pending_results [$];
	int mismatch_count = 0;
	int bytes_sent = 0;
	int quiet_cycles = 0;
	// Chance per byte, in percent, that the source pauses before offering it, and percentage of
	// cycles in which the result sink stalls.
	int gap_pct = 10;
	int stall_pct = 20;

	// Directed rows, walked in order straight after reset with the reset register values
	// in force, so the error totals in the typed rows can be read off by counting.
	frame_row_t directed_rows [13] = '{
		// Smallest good frame: empty payload, every header field zero.
		'{ROW_GOOD, 8'h00, 16'd0, 32'h0, 32'h0, 0, -1, 1'b1, sfp_pkg::STATUS_GOOD,
			0, 0, 0},
		// One payload byte with all-ones header fields.
		'{ROW_GOOD, 8'hFF, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, -1, 1'b0,
			sfp_pkg::STATUS_GOOD, 0, 0, 0},
		// Largest payload, led by repeated first start bytes.
		'{ROW_GOOD, 8'h5A, 16'd64, 32'h1234_5678, 32'h9ABC_DEF0, 2, -1, 1'b0,
			sfp_pkg::STATUS_GOOD, 0, 0, 0},
		// First start byte, a stray byte, then the second start byte: no frame begins.
		'{ROW_NOISE, 8'h00, 16'd3, 32'h0055_12AA, 32'h0, 0, -1, 1'b0,
			sfp_pkg::STATUS_GOOD, 0, 0, 0},
		// Length one above the payload limit.
		'{ROW_OVERSIZE, 8'h11, 16'h0041, 32'h0, 32'h0, 0, -1, 1'b1,
			sfp_pkg::STATUS_LEN_ERR, 0, 1, 0},
		// Length with every bit set.
		'{ROW_OVERSIZE, 8'h22, 16'hFFFF, 32'h0, 32'h0, 0, -1, 1'b1,
			sfp_pkg::STATUS_LEN_ERR, 0, 2, 0},
		'{ROW_BAD_VERSION, 8'h33, 16'd2, 32'h0000_0001, 32'h8000_0000, 0, -1, 1'b1,
			sfp_pkg::STATUS_VER_ERR, 0, 2, 1},
		// Corrupt CRC whose high byte is the first start byte.
		'{ROW_BAD_CRC, 8'h44, 16'd0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 8'hAA, 1'b1,
			sfp_pkg::STATUS_CRC_ERR, 1, 2, 1},
		// The second start byte straight after: the byte that closed the frame must not
		// have opened a new hunt.
		'{ROW_NOISE, 8'h00, 16'd1, 32'h0000_0055, 32'h0, 0, -1, 1'b0,
			sfp_pkg::STATUS_GOOD, 0, 0, 0},
		// Wrong version and wrong CRC together report the version only.
		'{ROW_BAD_BOTH, 8'h66, 16'd3, 32'h0, 32'h0, 0, -1, 1'b1,
			sfp_pkg::STATUS_VER_ERR, 1, 2, 2},
		'{ROW_GOOD, 8'h77, 16'd7, 32'hDEAD_BEEF, 32'h0102_0304, 0, -1, 1'b0,
			sfp_pkg::STATUS_GOOD, 0, 0, 0},
		// Two dangling first start bytes that run into the next frame's own.
		'{ROW_NOISE, 8'h00, 16'd2, 32'h0000_AAAA, 32'h0, 0, -1, 1'b0,
			sfp_pkg::STATUS_GOOD, 0, 0, 0},
		'{ROW_GOOD, 8'h81, 16'd0, 32'h8000_0000, 32'h0000_0001, 0, -1, 1'b0,
			sfp_pkg::STATUS_GOOD, 0, 0, 0}
	};

	// CRC-16/CCITT-FALSE, one bit at a time: the data bit enters at the top of the
	// register and the polynomial is folded in whenever the feedback bit is set.
	function automatic logic [15:0] crc_ccitt(input logic [15:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0};
			if (fb)
				c = c ^ sfp_pkg::CRC_POLY;
		end
		return c;
	endfunction

	// Everything belonging to the current frame goes back to its idle value; the error
	// totals and the registers are kept.
	function automatic void clear_frame();
		frame_pos = 0;
		frame_total = 0;
		hdr_type = '0;
		hdr_version = '0;
		hdr_len = '0;
		hdr_seq = '0;
		hdr_ts = '0;
		foreach (payload_mem[i])
			payload_mem[i] = '0;
		crc_acc = sfp_pkg::CRC_INIT;
		crc_low = '0;
	endfunction

	function automatic void note_error(input logic [1:0] code);
		frame_result_t r;
		if (code == sfp_pkg::STATUS_LEN_ERR)
			len_err_total++;
		else if (code == sfp_pkg::STATUS_VER_ERR)
			ver_err_total++;
		else
			crc_err_total++;
		clear_frame();
		r = '0;
		r.status = code;
		r.lst = 1'b1;
		r.crc_cnt = crc_err_total;
		r.len_cnt = len_err_total;
		r.ver_cnt = ver_err_total;
		pending_results.push_back(r);
	endfunction

	// Advances the shadow by one received byte and queues the results it causes.
	function automatic void predict_byte(input logic [7:0] b);
		int unsigned p;
		int unsigned nxt;
		int unsigned n;
		frame_result_t r;
		p = frame_pos;
		// Hunting: a repeat of the first start byte keeps the hunt at the second one.
		if (p == 0) begin
			if (b == start_first)
				frame_pos = 1;
			return;
		end
		if (p == sfp_pkg::HUNT_SECOND_POS) begin
			if (b == start_second)
				frame_pos = sfp_pkg::VERSION_POS;
			else if (b == start_first)
				frame_pos = 1;
			else
				frame_pos = 0;
			return;
		end
		if (p >= sfp_pkg::MAX_FRAME_BYTES_DEF) begin
			note_error(sfp_pkg::STATUS_LEN_ERR);
			return;
		end
		if (p < sfp_pkg::PAYLOAD_START || (frame_total != 0 && p + 2 < frame_total))
			crc_acc = crc_ccitt(crc_acc, b);
		if (p == sfp_pkg::VERSION_POS)
			hdr_version = b;
		else if (p == sfp_pkg::TYPE_POS)
			hdr_type = b;
		else if (p == sfp_pkg::LEN_LO_POS)
			hdr_len[7:0] = b;
		else if (p == sfp_pkg::LEN_HI_POS)
			hdr_len[15:8] = b;
		else if (p < sfp_pkg::TS_START)
			hdr_seq[8*(p-sfp_pkg::SEQ_START) +: 8] = b;
		else if (p < sfp_pkg::PAYLOAD_START)
			hdr_ts[8*(p-sfp_pkg::TS_START) +: 8] = b;
		else if (frame_total != 0 && p + 2 < frame_total)
			payload_mem[(p-sfp_pkg::PAYLOAD_START) % 64] = b;
		else if (frame_total != 0 && p + 2 == frame_total)
			crc_low = b;
		nxt = p + 1;
		frame_pos = nxt;
		// An oversize length is refused as soon as both of its bytes are in.
		if (nxt == sfp_pkg::LENGTH_DONE_POS) begin
			if (hdr_len > sfp_pkg::MAX_PAYLOAD_BYTES_DEF) begin
				note_error(sfp_pkg::STATUS_LEN_ERR);
				return;
			end
			frame_total = sfp_pkg::OVERHEAD_BYTES + hdr_len;
		end
		if (frame_total != 0 && nxt == frame_total) begin
			// The version is judged before the CRC.
			if (hdr_version != wanted_version) begin
				note_error(sfp_pkg::STATUS_VER_ERR);
				return;
			end
			if ({b, crc_low} != crc_acc) begin
				note_error(sfp_pkg::STATUS_CRC_ERR);
				return;
			end
			n = hdr_len;
			r = '0;
			r.status = sfp_pkg::STATUS_GOOD;
			r.ftype = hdr_type;
			r.plen = hdr_len[6:0];
			r.seq = hdr_seq;
			r.ts = hdr_ts;
			r.crc_cnt = crc_err_total;
			r.len_cnt = len_err_total;
			r.ver_cnt = ver_err_total;
			if (n == 0) begin
				r.lst = 1'b1;
				pending_results.push_back(r);
			end else begin
				for (int unsigned k = 0; k < n; k++) begin
					r.pbyte = payload_mem[k];
					r.bpos = k[5:0];
					r.lst = (k + 1 == n);
					pending_results.push_back(r);
				end
			end
			clear_frame();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at %0t ns: %s is %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Offers one byte and returns at the edge where the transaction completes. The
	// expectation is queued before the byte goes out; a result can only follow the
	// transaction, so the queue is always ahead of the result channel.
	task automatic send_byte(input logic [7:0] b, input bit use_typed,
		input frame_result_t typed_res);
		int held;
		held = pending_results.size();
		predict_byte(b);
		if (use_typed) begin
			while (pending_results.size() > held)
				void'(pending_results.pop_back());
			pending_results.push_back(typed_res);
		end
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!(rx_valid && rx_ready));
		bytes_sent++;
	endtask

	// Turns a row into bytes on the wire, using the registers currently in force.
	task automatic send_row(input frame_row_t row);
		logic [7:0]    bytes_q [$];
		logic [15:0]   crc;
		logic [15:0]   wire_crc;
		logic [7:0]    ver;
		int            body_start;
		int            lead;
		frame_result_t typed_res;
		if (row.kind == ROW_NOISE) begin
			for (int i = 0; i < row.len; i++)
				bytes_q.push_back(row.seq[8*i +: 8]);
		end else begin
			// With equal start bytes a repeat would already be the second start byte.
			lead = (start_first != start_second) ? row.repeats : 0;
			repeat (lead + 1) bytes_q.push_back(start_first);
			bytes_q.push_back(start_second);
			body_start = bytes_q.size();
			ver = wanted_version;
			if (row.kind == ROW_BAD_VERSION || row.kind == ROW_BAD_BOTH)
				ver = ver ^ 8'($urandom_range(1, 255));
			bytes_q.push_back(ver);
			bytes_q.push_back(row.ftype);
			bytes_q.push_back(row.len[7:0]);
			bytes_q.push_back(row.len[15:8]);
			if (row.kind != ROW_OVERSIZE) begin
				for (int i = 0; i < 4; i++)
					bytes_q.push_back(row.seq[8*i +: 8]);
				for (int i = 0; i < 4; i++)
					bytes_q.push_back(row.ts[8*i +: 8]);
				for (int i = 0; i < row.len; i++)
					bytes_q.push_back(8'($urandom));
				crc = sfp_pkg::CRC_INIT;
				for (int i = body_start; i < bytes_q.size(); i++)
					crc = crc_ccitt(crc, bytes_q[i]);
				wire_crc = crc;
				if (row.kind == ROW_BAD_CRC || row.kind == ROW_BAD_BOTH) begin
					wire_crc = crc ^ 16'($urandom_range(1, 65535));
					if (row.crc_tail >= 0) begin
						wire_crc[15:8] = 8'(row.crc_tail);
						if (wire_crc == crc)
							wire_crc[0] = ~wire_crc[0];
					end
				end
				bytes_q.push_back(wire_crc[7:0]);
				bytes_q.push_back(wire_crc[15:8]);
			end
		end
		typed_res = '0;
		typed_res.status = row.t_status;
		typed_res.lst = 1'b1;
		typed_res.crc_cnt = row.t_crc;
		typed_res.len_cnt = row.t_len;
		typed_res.ver_cnt = row.t_ver;
		foreach (bytes_q[i])
			send_byte(bytes_q[i], row.typed && i == bytes_q.size() - 1, typed_res);
	endtask

	// Random frames: mostly well formed with random content, the rest broken in each of
	// the ways the parser recognises, plus loose bytes that tease the start-byte hunt.
	// Payloads are mostly short so that many frames fit; a few go up to the limit.
	task automatic random_traffic(input int n_bytes);
		frame_row_t row;
		int         goal;
		int         r;
		goal = bytes_sent + n_bytes;
		while (bytes_sent < goal) begin
			row.ftype = 8'($urandom);
			row.seq = $urandom;
			row.ts = $urandom;
			row.repeats = ($urandom_range(99) < 20) ? $urandom_range(1, 2) : 0;
			row.crc_tail = -1;
			row.typed = 1'b0;
			row.t_status = sfp_pkg::STATUS_GOOD;
			row.t_crc = '0;
			row.t_len = '0;
			row.t_ver = '0;
			r = $urandom_range(99);
			if (r < 55)
				row.kind = ROW_GOOD;
			else if (r < 65)
				row.kind = ROW_BAD_VERSION;
			else if (r < 75)
				row.kind = ROW_BAD_CRC;
			else if (r < 80)
				row.kind = ROW_BAD_BOTH;
			else if (r < 88)
				row.kind = ROW_OVERSIZE;
			else
				row.kind = ROW_NOISE;
			r = $urandom_range(99);
			if (r < 75)
				row.len = 16'($urandom_range(0, 8));
			else if (r < 95)
				row.len = 16'($urandom_range(9, 31));
			else
				row.len = 16'($urandom_range(32, sfp_pkg::MAX_PAYLOAD_BYTES_DEF));
			if (row.kind == ROW_OVERSIZE) begin
				if ($urandom_range(1) == 0)
					row.len = 16'($urandom_range(sfp_pkg::MAX_PAYLOAD_BYTES_DEF + 1, 255));
				else
					row.len = {8'($urandom_range(1, 255)), 8'($urandom)};
			end
			if (row.kind == ROW_NOISE) begin
				row.len = 16'($urandom_range(1, 4));
				for (int i = 0; i < 4; i++) begin
					r = $urandom_range(99);
					row.seq[8*i +: 8] = (r < 25) ? start_first :
						(r < 40) ? start_second : 8'($urandom);
				end
			end
			send_row(row);
		end
	endtask

	// Stops offering bytes and waits until every expected result has been taken. The
	// last byte may have caused nothing, so it then lets the parser settle before anything
	// else touches it.
	task automatic settle();
		rx_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all three registers, one per cycle, and keeps the shadow in step.
	task automatic load_config(input logic [7:0] first_byte, input logic [7:0] second_byte,
		input logic [7:0] version);
		logic [sfp_pkg::CFG_IDX_W-1:0] idx [3];
		logic [sfp_pkg::CFG_W-1:0]     val [3];
		idx = '{sfp_pkg::CFG_START_FIRST, sfp_pkg::CFG_START_SECOND, sfp_pkg::CFG_EXP_VERSION};
		val = '{first_byte, second_byte, version};
		start_first = first_byte;
		start_second = second_byte;
		wanted_version = version;
		for (int i = 0; i < 3; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_wr_data <= val[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// The result sink stalls at random; with stall_pct at zero it takes every result.
	always @(posedge clk)
		res_ready <= ($urandom_range(99) >= stall_pct);

	// Each result transaction is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected, status", status, 0);
			end else begin
				want = pending_results.pop_front();
				check_field("status", status, want.status);
				check_field("frame_type", frame_type, want.ftype);
				check_field("payload_length", payload_length, want.plen);
				check_field("sequence_number", sequence_number, want.seq);
				check_field("timestamp", timestamp, want.ts);
				check_field("payload_byte", payload_byte, want.pbyte);
				check_field("byte_position", byte_position, want.bpos);
				check_field("last", last, want.lst);
				check_field("crc_error_count", crc_error_count, want.crc_cnt);
				check_field("length_error_count", length_error_count, want.len_cnt);
				check_field("version_error_count", version_error_count, want.ver_cnt);
			end
		end
	end

	// A run that stops moving has hung, or is waiting for a result that never comes.
	always @(posedge clk) begin
		if (!arst_n || (rx_valid && rx_ready) || (res_valid && res_ready) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [7:0] shared_start;
		start_first = sfp_pkg::START_FIRST_RST;
		start_second = sfp_pkg::START_SECOND_RST;
		wanted_version = sfp_pkg::EXP_VERSION_RST;
		crc_err_total = '0;
		len_err_total = '0;
		ver_err_total = '0;
		clear_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows under the reset register values.
		foreach (directed_rows[i])
			send_row(directed_rows[i]);
		settle();
		random_traffic(50);

		// All-zeros and all-ones register values.
		settle();
		load_config(8'h00, 8'hFF, 8'hFF);
		random_traffic(50);

		// The opposite extremes, with neither side ever pausing.
		settle();
		gap_pct = 0;
		stall_pct = 0;
		load_config(8'hFF, 8'h00, 8'h00);
		random_traffic(50);

		// Both start bytes the same value, so a repeat of it confirms the hunt rather than restarting it.
		settle();
		gap_pct = 10;
		stall_pct = 20;
		shared_start = 8'($urandom);
		load_config(shared_start, shared_start, 8'($urandom));
		random_traffic(50);

		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
+incdir+src
src/sfp_pkg.sv
src/sfp_dp.sv
src/sfp_ctrl.sv
src/sof_length_crc_frame_parser.sv
test/tb_sof_length_crc_frame_parser.sv
